// ===== rtl/cftd_pkg.sv =====
package cftd_pkg;

  // default sizes
  localparam int CHANNELS_DEF    = 10;
  localparam int SAMPLE_BITS_DEF = 12;

  // fixed field widths
  localparam int CH_W      = 4;
  localparam int SLACK_W   = 11;
  localparam int SAMPLES_W = 4;
  localparam int SUM_W     = 16;
  localparam int CNT_W     = 4;
  localparam int DIV_W     = CNT_W + 1;
  localparam int IDX_MAX_W = 6;
  localparam int FRAC_W    = 10;

  // configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = SLACK_W;
  localparam logic [CFG_IDX_W-1:0] CFG_SLACK   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_SAMPLES = 1'b1;

  localparam logic [SLACK_W-1:0]   SLACK_RESET   = 11'd1004;
  localparam logic [SAMPLES_W-1:0] SAMPLES_RESET = 4'd10;

  // operation codes
  localparam logic OP_DETECT    = 1'b0;
  localparam logic OP_CALIBRATE = 1'b1;

  // factory thresholds, channels past the table start at zero
  function automatic logic [15:0] cftd_factory(input logic [IDX_MAX_W-1:0] idx);
    logic [15:0] val;
    case (idx)
      6'd0:    val = 16'd2800;
      6'd1:    val = 16'd2500;
      6'd2:    val = 16'd2700;
      6'd3:    val = 16'd2400;
      6'd4:    val = 16'd2900;
      6'd5:    val = 16'd2300;
      6'd6:    val = 16'd2400;
      6'd7:    val = 16'd2300;
      6'd8:    val = 16'd2600;
      6'd9:    val = 16'd2600;
      default: val = 16'd0;
    endcase
    return val;
  endfunction

endpackage

// ===== rtl/cftd_state_mem.sv =====
module cftd_state_mem import cftd_pkg::*; #(
  parameter int CHANNELS    = CHANNELS_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  localparam int ADDR_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1,
  localparam int ENTRY_W = SAMPLE_BITS + SUM_W + CNT_W
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               rd_en,
  input  logic [ADDR_W-1:0]  rd_addr,
  output logic [ENTRY_W-1:0] rd_data,
  input  logic               wr_en,
  input  logic [ADDR_W-1:0]  wr_addr,
  input  logic [ENTRY_W-1:0] wr_data
);

  logic [ENTRY_W-1:0]  mem_r [CHANNELS];
  logic [CHANNELS-1:0] valid_r;
  logic [ENTRY_W-1:0]  q_r;
  logic                q_valid_r;
  logic [ADDR_W-1:0]   q_addr_r;
  logic [15:0]         factory;

  // per-channel state memory, one read and one write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      q_r      <= mem_r[rd_addr];
      q_addr_r <= rd_addr;
    end
  end

  // written flags, an unwritten entry reads as its reset value
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r   <= '0;
      q_valid_r <= 1'b0;
    end else begin
      if (wr_en) begin
        valid_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        q_valid_r <= valid_r[rd_addr];
      end
    end
  end

  assign factory = cftd_factory(IDX_MAX_W'(q_addr_r));
  assign rd_data = q_valid_r ? q_r
                             : {factory[SAMPLE_BITS-1:0], {SUM_W{1'b0}}, {CNT_W{1'b0}}};

endmodule

// ===== rtl/cftd_divider.sv =====
module cftd_divider import cftd_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [SUM_W-1:0] dividend,
  input  logic [DIV_W-1:0] divisor,
  output logic             done,
  output logic [SUM_W-1:0] quotient
);

  localparam int STEP_W = $clog2(SUM_W);

  logic              busy_r;
  logic              done_r;
  logic [STEP_W-1:0] step_r;
  logic [SUM_W-1:0]  quot_r;
  logic [DIV_W-1:0]  rem_r;
  logic [DIV_W-1:0]  dvs_r;
  logic [DIV_W:0]    trial;
  logic              fits;
  logic [DIV_W-1:0]  rem_nxt;

  // one restoring step: shift in the next dividend bit and try a subtract
  assign trial   = {rem_r, quot_r[SUM_W-1]};
  assign fits    = trial >= {1'b0, dvs_r};
  assign rem_nxt = fits ? DIV_W'(trial - {1'b0, dvs_r}) : trial[DIV_W-1:0];

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= '0;
      end else if (busy_r) begin
        step_r <= step_r + STEP_W'(1);
        if (step_r == STEP_W'(SUM_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      quot_r <= dividend;
      rem_r  <= '0;
      dvs_r  <= divisor;
    end else if (busy_r) begin
      quot_r <= {quot_r[SUM_W-2:0], fits};
      rem_r  <= rem_nxt;
    end
  end

  assign done     = done_r;
  assign quotient = quot_r;

  // a new division only starts when idle
  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> !busy_r) else $error("divider started while busy");

  // completion is a single pulse after the last step
  a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> !busy_r && $past(busy_r)) else $error("divider done without busy");

  // a divisor of zero never enters
  a_divisor_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> divisor != '0) else $error("divider started with zero divisor");

endmodule

// ===== rtl/calibrated_flex_threshold_detector.sv =====
// flow: an accepted item passes S_READ, then S_CMP for a detect item or S_DIV (waiting on the
// bit-serial divider) for a calibrate item that finishes an average, then S_OUT; out-of-range
// channels and calibrate items that do not finish an average go from S_READ straight to S_OUT
// one item at a time: a new item is taken only once the last result is in the output register
// reset: synchronous active-low; thresholds read as the factory table, sums and counts as zero

module calibrated_flex_threshold_detector import cftd_pkg::*; #(
  parameter int CHANNELS    = CHANNELS_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // configuration
  input  logic                   cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata,
  // input channel
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic                   in_operation,
  input  logic [CH_W-1:0]        in_channel,
  input  logic [SAMPLE_BITS-1:0] in_sample,
  // result channel
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic                   out_flexed,
  output logic                   out_threshold_updated,
  output logic [SAMPLE_BITS-1:0] out_current_threshold
);

  localparam int ADDR_W    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int ENTRY_W   = SAMPLE_BITS + SUM_W + CNT_W;
  localparam int PROD_W    = SLACK_W + SAMPLE_BITS;
  localparam int SUM_EXT_W = SUM_W + 1;
  localparam int CH_EXT_W  = IDX_MAX_W + 1;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_READ = 3'd1;
  localparam logic [2:0] S_CMP  = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_OUT  = 3'd4;

  logic [2:0]             state_r, state_nxt;
  logic [SLACK_W-1:0]     slack_r;
  logic [SAMPLES_W-1:0]   samples_r;
  logic                   op_r;
  logic                   ch_ok_r;
  logic [SAMPLE_BITS-1:0] smp_r;
  logic [ADDR_W-1:0]      addr_r;
  logic [PROD_W-1:0]      prod_r;
  logic                   res_flexed_r, res_flexed_nxt;
  logic                   res_upd_r, res_upd_nxt;
  logic [SAMPLE_BITS-1:0] res_thr_r, res_thr_nxt;
  logic                   out_valid_r;
  logic                   out_flexed_r;
  logic                   out_upd_r;
  logic [SAMPLE_BITS-1:0] out_thr_r;

  logic                   in_accept;
  logic [CH_EXT_W-1:0]    ch_ext;
  logic                   ch_ok;
  logic [ADDR_W-1:0]      in_addr;
  logic [ENTRY_W-1:0]     rd_data;
  logic                   mem_wr;
  logic [ENTRY_W-1:0]     wr_data;
  logic [SAMPLE_BITS-1:0] thr_q;
  logic [SUM_W-1:0]       sum_q;
  logic [CNT_W-1:0]       cnt_q;
  logic [SUM_EXT_W-1:0]   sum_add;
  logic [SUM_W-1:0]       sum_sat;
  logic [DIV_W-1:0]       cnt_inc;
  logic                   avg_done;
  logic                   div_start;
  logic                   div_done;
  logic [SUM_W-1:0]       div_quot;
  logic [PROD_W-1:0]      lhs;
  logic                   load_out;

  // input side
  assign in_stall  = state_r != S_IDLE;
  assign in_accept = in_valid && !in_stall;
  assign ch_ext    = CH_EXT_W'(in_channel);
  assign ch_ok     = ch_ext < CH_EXT_W'(CHANNELS);
  assign in_addr   = ch_ext[ADDR_W-1:0];

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slack_r   <= SLACK_RESET;
      samples_r <= SAMPLES_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_SLACK:   slack_r   <= cfg_wdata;
        CFG_SAMPLES: samples_r <= cfg_wdata[SAMPLES_W-1:0];
        default: ;
      endcase
    end
  end

  cftd_state_mem #(
    .CHANNELS    (CHANNELS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (in_accept && ch_ok),
    .rd_addr (in_addr),
    .rd_data (rd_data),
    .wr_en   (mem_wr),
    .wr_addr (addr_r),
    .wr_data (wr_data)
  );

  cftd_divider u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (sum_sat),
    .divisor  (cnt_inc),
    .done     (div_done),
    .quotient (div_quot)
  );

  // read-modify of the channel entry
  assign thr_q    = rd_data[ENTRY_W-1 -: SAMPLE_BITS];
  assign sum_q    = rd_data[CNT_W +: SUM_W];
  assign cnt_q    = rd_data[CNT_W-1:0];
  assign sum_add  = {1'b0, sum_q} + SUM_EXT_W'(smp_r);
  assign sum_sat  = sum_add[SUM_W] ? {SUM_W{1'b1}} : sum_add[SUM_W-1:0];
  assign cnt_inc  = {1'b0, cnt_q} + DIV_W'(1);
  assign avg_done = cnt_inc >= {1'b0, samples_r};
  assign lhs      = {1'b0, smp_r, {FRAC_W{1'b0}}};
  assign load_out = (state_r == S_OUT) && (!out_valid_r || !out_stall);

  // sequencer
  always_comb begin
    state_nxt      = state_r;
    res_flexed_nxt = res_flexed_r;
    res_upd_nxt    = res_upd_r;
    res_thr_nxt    = res_thr_r;
    mem_wr         = 1'b0;
    wr_data        = {thr_q, sum_sat, cnt_inc[CNT_W-1:0]};
    div_start      = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_accept) begin
          state_nxt = S_READ;
        end
      end
      S_READ: begin
        res_flexed_nxt = 1'b0;
        res_upd_nxt    = 1'b0;
        res_thr_nxt    = thr_q;
        if (!ch_ok_r) begin
          res_thr_nxt = '0;
          state_nxt   = S_OUT;
        end else if (op_r == OP_DETECT) begin
          state_nxt = S_CMP;
        end else if (avg_done) begin
          div_start = 1'b1;
          state_nxt = S_DIV;
        end else begin
          mem_wr    = 1'b1;
          state_nxt = S_OUT;
        end
      end
      S_CMP: begin
        res_flexed_nxt = lhs >= prod_r;
        state_nxt      = S_OUT;
      end
      S_DIV: begin
        wr_data = {div_quot[SAMPLE_BITS-1:0], {SUM_W{1'b0}}, {CNT_W{1'b0}}};
        if (div_done) begin
          mem_wr      = 1'b1;
          res_upd_nxt = 1'b1;
          res_thr_nxt = div_quot[SAMPLE_BITS-1:0];
          state_nxt   = S_OUT;
        end
      end
      S_OUT: begin
        if (load_out) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // item and result staging
  always_ff @(posedge clk) begin
    if (in_accept) begin
      op_r    <= in_operation;
      ch_ok_r <= ch_ok;
      smp_r   <= in_sample;
      addr_r  <= in_addr;
    end
    if (state_r == S_READ) begin
      prod_r <= PROD_W'(slack_r) * PROD_W'(thr_q);
    end
    res_flexed_r <= res_flexed_nxt;
    res_upd_r    <= res_upd_nxt;
    res_thr_r    <= res_thr_nxt;
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_flexed_r <= res_flexed_r;
      out_upd_r    <= res_upd_r;
      out_thr_r    <= res_thr_r;
    end
  end

  assign out_valid             = out_valid_r;
  assign out_flexed            = out_flexed_r;
  assign out_threshold_updated = out_upd_r;
  assign out_current_threshold = out_thr_r;

  // no state write can race a new read of the same entry
  a_write_not_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
    mem_wr |-> !in_accept) else $error("state write while accepting a beat");

  // divider completion only seen while waiting for it
  a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> state_r == S_DIV) else $error("divider done outside wait state");

  // a result beat never carries both flags
  a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_flexed_r && out_upd_r)) else $error("flexed and updated together");

  // a new result is only loaded once the previous beat has left
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    load_out |-> !(out_valid_r && out_stall)) else $error("result overwritten");

endmodule

// ===== dv/calibrated_flex_threshold_detector_tb.sv =====
module calibrated_flex_threshold_detector_tb;
  import cftd_pkg::*;

  localparam int NCH         = CHANNELS_DEF;
  localparam int SB          = SAMPLE_BITS_DEF;
  localparam int SMP_MAX     = (1 << SB) - 1;
  localparam int CYCLE_LIMIT = 400000;
  localparam int TAIL_CYCLES = 40;
  localparam int PHASE_ITEMS = 200;

  typedef struct packed {
    logic          op;
    logic [CH_W-1:0] ch;
    logic [SB-1:0] smp;
  } probe_t;

  typedef struct packed {
    logic          flexed;
    logic          updated;
    logic [SB-1:0] thr;
  } reading_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic                  in_operation = OP_DETECT;
  logic [CH_W-1:0]       in_channel = '0;
  logic [SB-1:0]         in_sample = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic                  out_flexed;
  logic                  out_threshold_updated;
  logic [SB-1:0]         out_current_threshold;

  // detector state as the testbench sees it
  logic [SLACK_W-1:0]   slack_q;
  logic [SAMPLES_W-1:0] avg_len;
  logic [SB-1:0]        thr_tbl [NCH];
  logic [SUM_W-1:0]     sum_tbl [NCH];
  logic [CNT_W-1:0]     cnt_tbl [NCH];
  int                   factory_thr [NCH] = '{2800, 2500, 2700, 2400, 2900,
                                              2300, 2400, 2300, 2600, 2600};

  probe_t   probe_backlog [$];
  reading_t pending_readings [$];

  int errors = 0;
  int cycles = 0;
  int n_beats_in = 0;
  int n_results = 0;
  int n_updates = 0;
  int n_flexed = 0;
  int n_off_range = 0;
  int n_cfg = 0;
  logic calm;

  // no idling on either side for a long stretch of beats
  assign calm = (n_beats_in >= 500) && (n_beats_in < 800);

  calibrated_flex_threshold_detector #(
    .CHANNELS    (NCH),
    .SAMPLE_BITS (SB)
  ) u_top (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cfg_wr_en             (cfg_wr_en),
    .cfg_index             (cfg_index),
    .cfg_wdata             (cfg_wdata),
    .in_valid              (in_valid),
    .in_stall              (in_stall),
    .in_operation          (in_operation),
    .in_channel            (in_channel),
    .in_sample             (in_sample),
    .out_valid             (out_valid),
    .out_stall             (out_stall),
    .out_flexed            (out_flexed),
    .out_threshold_updated (out_threshold_updated),
    .out_current_threshold (out_current_threshold)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // work out the reading an accepted beat must produce and update channel state
  function automatic void evaluate_probe(input logic op, input logic [CH_W-1:0] ch,
                                         input logic [SB-1:0] smp);
    reading_t   r;
    logic [23:0] lhs;
    logic [23:0] rhs;
    logic [16:0] s;
    logic [4:0]  c;
    r = '0;
    if (ch < NCH) begin
      if (op == OP_DETECT) begin
        lhs = 24'(smp) << FRAC_W;
        rhs = 24'(slack_q) * 24'(thr_tbl[ch]);
        r.flexed = (lhs >= rhs);
        if (r.flexed) n_flexed++;
      end else begin
        s = 17'(sum_tbl[ch]) + 17'(smp);
        if (s > 17'h0FFFF) s = 17'h0FFFF;
        c = 5'(cnt_tbl[ch]) + 5'd1;
        // a count of zero behaves like one, a lowered count completes at once
        if (c >= 5'(avg_len)) begin
          thr_tbl[ch] = SB'(s / 17'(c));
          sum_tbl[ch] = '0;
          cnt_tbl[ch] = '0;
          r.updated = 1'b1;
          n_updates++;
        end else begin
          sum_tbl[ch] = s[SUM_W-1:0];
          cnt_tbl[ch] = c[CNT_W-1:0];
        end
      end
      r.thr = thr_tbl[ch];
    end else begin
      n_off_range++;
    end
    pending_readings.push_back(r);
  endfunction

  function automatic void queue_probe(input logic op, input logic [CH_W-1:0] ch,
                                      input logic [SB-1:0] smp);
    probe_t p;
    p.op  = op;
    p.ch  = ch;
    p.smp = smp;
    probe_backlog.push_back(p);
  endfunction

  // extremes often, anything in range otherwise
  function automatic logic [SB-1:0] pick_sample();
    int k;
    k = $urandom_range(99);
    if (k < 10) return '0;
    if (k < 20) return SB'(SMP_MAX);
    return SB'($urandom_range(SMP_MAX));
  endfunction

  // one register write, taken at the following edge
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int val);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= CFG_DATA_W'(val);
    if (idx == CFG_SLACK) slack_q = SLACK_W'(val);
    else avg_len = SAMPLES_W'(val);
    n_cfg++;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // wait until every queued beat went in and every reading came back
  task automatic drain();
    @(negedge clk);
    while (probe_backlog.size() != 0 || in_valid || pending_readings.size() != 0)
      @(negedge clk);
  endtask

  // input driver
  always @(posedge clk) begin : driver
    probe_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        evaluate_probe(in_operation, in_channel, in_sample);
        n_beats_in++;
      end
      if (!in_valid || !in_stall) begin
        if (probe_backlog.size() != 0 && (calm || $urandom_range(99) >= 24)) begin
          nxt = probe_backlog.pop_front();
          in_valid     <= 1'b1;
          in_operation <= nxt.op;
          in_channel   <= nxt.ch;
          in_sample    <= nxt.smp;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor and receiver stalls
  always @(posedge clk) begin : monitor
    reading_t want;
    reading_t got;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        n_results++;
        got.flexed  = out_flexed;
        got.updated = out_threshold_updated;
        got.thr     = out_current_threshold;
        if (pending_readings.size() == 0) begin
          errors++;
          $display("%0t: result beat with nothing pending: flexed=%0b updated=%0b thr=%0d",
                   $time, got.flexed, got.updated, got.thr);
        end else begin
          want = pending_readings.pop_front();
          if (got.flexed !== want.flexed) begin
            errors++;
            $display("%0t: flexed mismatch, expected %0b actual %0b",
                     $time, want.flexed, got.flexed);
          end
          if (got.updated !== want.updated) begin
            errors++;
            $display("%0t: threshold_updated mismatch, expected %0b actual %0b",
                     $time, want.updated, got.updated);
          end
          if (got.thr !== want.thr) begin
            errors++;
            $display("%0t: current_threshold mismatch, expected %0d actual %0d",
                     $time, want.thr, got.thr);
          end
        end
      end
      out_stall <= !calm && ($urandom_range(99) < 24);
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d readings pending", $time, pending_readings.size());
      $display("calibrated_flex_threshold_detector regression: fail");
      $finish;
    end
  end

  initial begin : stimulus
    int kind;
    int bch;
    int blen;
    int n_queued;
    int sl;
    int na;
    slack_q = SLACK_RESET;
    avg_len = SAMPLES_RESET;
    for (int i = 0; i < NCH; i++) begin
      thr_tbl[i] = SB'(factory_thr[i]);
      sum_tbl[i] = '0;
      cnt_tbl[i] = '0;
    end
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // detect extremes and the exact boundary on channel 0 at reset settings
    queue_probe(OP_DETECT, 0, 0);
    queue_probe(OP_DETECT, 0, SB'(SMP_MAX));
    queue_probe(OP_DETECT, 0, 2745);
    queue_probe(OP_DETECT, 0, 2746);
    // channels past the table give a result beat with no flag and a zero threshold
    queue_probe(OP_DETECT, 10, SB'(SMP_MAX));
    queue_probe(OP_CALIBRATE, 15, SB'(SMP_MAX));
    // full average at the reset sample count
    repeat (10) queue_probe(OP_CALIBRATE, 1, SB'(SMP_MAX));
    queue_probe(OP_DETECT, 1, SB'(SMP_MAX));
    drain();

    // zero slack and single-sample average
    write_reg(CFG_SLACK, 0);
    write_reg(CFG_SAMPLES, 1);
    queue_probe(OP_CALIBRATE, 2, 0);
    queue_probe(OP_DETECT, 2, 0);
    drain();

    // slack above one, zero sample count acts like one
    write_reg(CFG_SLACK, 2047);
    write_reg(CFG_SAMPLES, 0);
    queue_probe(OP_CALIBRATE, 3, 100);
    queue_probe(OP_DETECT, 3, SB'(SMP_MAX));
    drain();

    // sample count lowered below what was already gathered
    write_reg(CFG_SAMPLES, 15);
    repeat (4) queue_probe(OP_CALIBRATE, 4, pick_sample());
    drain();
    write_reg(CFG_SAMPLES, 2);
    queue_probe(OP_CALIBRATE, 4, pick_sample());

    // random phases, each under its own settings
    for (int ph = 0; ph < 6; ph++) begin
      drain();
      case (ph)
        0: begin sl = 1024; na = 15; end
        1: begin sl = 0;    na = 1;  end
        2: begin sl = 2047; na = 0;  end
        3: begin sl = 1004; na = 10; end
        default: begin
          sl = $urandom_range(2047);
          na = $urandom_range(15);
        end
      endcase
      write_reg(CFG_SLACK, sl);
      write_reg(CFG_SAMPLES, na);
      n_queued = 0;
      while (n_queued < PHASE_ITEMS) begin
        kind = $urandom_range(99);
        if (kind < 35) begin
          // calibration burst on one channel, mostly a whole average
          bch  = $urandom_range(NCH - 1);
          blen = (kind < 8) ? $urandom_range(1, 15) : ((avg_len == 0) ? 1 : int'(avg_len));
          repeat (blen) queue_probe(OP_CALIBRATE, CH_W'(bch), pick_sample());
          n_queued += blen;
        end else if (kind < 45) begin
          queue_probe(1'($urandom_range(1)), CH_W'($urandom_range(15, NCH)), pick_sample());
          n_queued++;
        end else begin
          queue_probe(1'($urandom_range(1)), CH_W'($urandom_range(NCH - 1)), pick_sample());
          n_queued++;
        end
      end
    end

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("covered %0d input beats (%0d on unused channels) under %0d register writes",
             n_beats_in, n_off_range, n_cfg);
    $display("checked %0d readings: %0d threshold updates, %0d flexed detections",
             n_results, n_updates, n_flexed);
    if (errors == 0 && pending_readings.size() == 0) begin
      $display("calibrated_flex_threshold_detector regression: pass");
    end else begin
      $display("calibrated_flex_threshold_detector regression: fail");
    end
    $finish;
  end

endmodule
